// ===== sv/rbgr_pkg.sv =====
`default_nettype none

package rbgr_pkg;

    // default number of micro-ops the ring can hold
    localparam int ROB_ENTRIES_DEF = 31;

    localparam int WIDTH_W = 4;
    localparam logic [WIDTH_W-1:0] RETIRE_WIDTH_RESET = 4'd4;

    typedef logic [WIDTH_W-1:0] t_width;

    typedef enum logic [1:0] {
        OP_ALLOC    = 2'd0,
        OP_COMPLETE = 2'd1,
        OP_RETIRE   = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0] operation;
        logic       last_in_inst;
        logic       station_free;
        logic [4:0] slot_index;
    } t_req;

    typedef struct packed {
        logic       accepted;
        logic [4:0] granted_slot;
        logic [3:0] retired_count;
        logic [4:0] occupancy;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_CHECK,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

// ===== sv/rbgr_chan_if.sv =====
`default_nettype none

interface rbgr_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/reorder_buffer_group_retire.sv =====
// reorder buffer with whole-instruction retirement
//
// channels: i_req carries one command transaction (allocate, complete or retire
// cycle), o_rsp returns exactly one result transaction per command, i_cfg
// writes the retire width (always ready, write only while the block is idle).
// valid/ready handshake on every channel; a transaction moves when both are high.
//
// the block takes one command at a time: i_req.ready is high only while idle.
// allocate, complete and unused codes pass through the exec and fin states;
// fin raises o_rsp.valid and goes back to idle to accept the next command.
// a retire cycle scans the ring from the head, each scan step passing the read
// and check states of the end-mark memory read port: one step per slot passed
// plus the step that stops, at most retire_width + 1 steps.
//
// results sit in an output register; when the receiver stalls the block can
// still take the next command, and only holds its finished result back until
// the output register frees up.
//
// reset (synchronous, active low) empties the ring, clears all done bits and
// sets the retire width to 4; no clearing pass, the block is ready at once.
`default_nettype none

module reorder_buffer_group_retire #(
    parameter int ROB_ENTRIES = rbgr_pkg::ROB_ENTRIES_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    rbgr_chan_if.sink         i_req,
    rbgr_chan_if.source       o_rsp,
    rbgr_chan_if.sink         i_cfg
);

    localparam int RING_SLOTS = ROB_ENTRIES + 1;
    localparam int PTR_W      = $clog2(RING_SLOTS);
    localparam int CNT_W      = $clog2(ROB_ENTRIES + 1);
    localparam int CW         = (CNT_W > rbgr_pkg::WIDTH_W) ? CNT_W : rbgr_pkg::WIDTH_W;
    localparam int SW         = ((PTR_W > 5) ? PTR_W : 5) + 1;

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [CNT_W-1:0] t_cnt;

    function automatic t_ptr ring_next(input t_ptr p);
        ring_next = (p == PTR_W'(RING_SLOTS - 1)) ? '0 : p + t_ptr'(1);
    endfunction

    // control state
    rbgr_pkg::t_state        r_state, n_state;
    t_ptr                    r_head, n_head;
    t_ptr                    r_tail, n_tail;
    t_cnt                    r_count, n_count;
    logic [RING_SLOTS-1:0]   r_done, n_done;
    rbgr_pkg::t_width        r_width, n_width;
    logic                    r_out_valid, n_out_valid;

    // payload and scan datapath
    rbgr_pkg::t_req          r_item, n_item;
    rbgr_pkg::t_rsp          r_res, n_res;
    rbgr_pkg::t_rsp          r_out, n_out;
    t_ptr                    r_scan, n_scan;
    logic [3:0]              r_pend, n_pend;
    logic [3:0]              r_left, n_left;
    logic [3:0]              r_retired, n_retired;

    // end-of-instruction marks: one write port, one registered read port
    logic                    r_end_mem [RING_SLOTS];
    logic                    r_end_q;
    logic                    mem_we;

    // helpers
    logic                    out_free;
    logic                    ring_full;
    logic [SW-1:0]           slot_ext, head_ext, slot_off;
    logic                    slot_held;
    logic [3:0]              grp;
    logic                    scan_stop;

    assign i_req.ready = (r_state == rbgr_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    assign out_free  = !r_out_valid || o_rsp.ready;
    assign ring_full = (r_head == ring_next(r_tail));

    // distance of the completed slot from the head, modulo the ring size
    assign slot_ext  = SW'(r_item.slot_index);
    assign head_ext  = SW'(r_head);
    assign slot_off  = (slot_ext >= head_ext) ? (slot_ext - head_ext)
                                              : (slot_ext + SW'(RING_SLOTS) - head_ext);
    assign slot_held = (slot_ext < SW'(RING_SLOTS)) && (slot_off < SW'(r_count));

    // scan: the group grows by the slot under the scan pointer
    assign grp       = r_pend + 4'd1;
    assign scan_stop = (r_pend == r_left)
                    || (CW'(r_pend) == CW'(r_count))
                    || !r_done[r_scan];

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_done      = r_done;
        n_width     = r_width;
        n_out_valid = r_out_valid;
        n_item      = r_item;
        n_res       = r_res;
        n_out       = r_out;
        n_scan      = r_scan;
        n_pend      = r_pend;
        n_left      = r_left;
        n_retired   = r_retired;
        mem_we      = 1'b0;

        if (i_cfg.valid) begin
            n_width = i_cfg.data;
        end

        // output register drains independently of the sequencer
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            rbgr_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_item  = i_req.data;
                    n_state = rbgr_pkg::ST_EXEC;
                end
            end
            rbgr_pkg::ST_EXEC: begin
                n_res   = '0;
                n_state = rbgr_pkg::ST_FIN;
                case (r_item.operation)
                    rbgr_pkg::OP_ALLOC: begin
                        if (r_item.station_free && !ring_full) begin
                            mem_we               = 1'b1;
                            n_done[r_tail]       = 1'b0;
                            n_tail               = ring_next(r_tail);
                            n_count              = r_count + t_cnt'(1);
                            n_res.accepted       = 1'b1;
                            n_res.granted_slot   = 5'(r_tail);
                        end
                        n_res.occupancy = 5'(n_count);
                    end
                    rbgr_pkg::OP_COMPLETE: begin
                        if (slot_held) begin
                            n_done[t_ptr'(r_item.slot_index)] = 1'b1;
                        end
                        n_res.accepted  = 1'b1;
                        n_res.occupancy = 5'(r_count);
                    end
                    rbgr_pkg::OP_RETIRE: begin
                        n_left    = r_width;
                        n_retired = '0;
                        n_pend    = '0;
                        n_scan    = r_head;
                        n_state   = rbgr_pkg::ST_READ;
                    end
                    default: begin
                        n_res.occupancy = 5'(r_count);
                    end
                endcase
            end
            rbgr_pkg::ST_READ: begin
                // end mark at the scan pointer is fetched this cycle
                n_state = rbgr_pkg::ST_CHECK;
            end
            rbgr_pkg::ST_CHECK: begin
                if (scan_stop) begin
                    // budget spent, ring exhausted or an unfinished micro-op
                    n_res.accepted      = 1'b1;
                    n_res.granted_slot  = '0;
                    n_res.retired_count = r_retired;
                    n_res.occupancy     = 5'(r_count);
                    n_state             = rbgr_pkg::ST_FIN;
                end else if (r_end_q) begin
                    // whole instruction ready and within budget: retire it
                    n_head    = ring_next(r_scan);
                    n_scan    = ring_next(r_scan);
                    n_count   = r_count - t_cnt'(grp);
                    n_left    = r_left - grp;
                    n_retired = r_retired + grp;
                    n_pend    = '0;
                    n_state   = rbgr_pkg::ST_READ;
                end else begin
                    n_pend  = grp;
                    n_scan  = ring_next(r_scan);
                    n_state = rbgr_pkg::ST_READ;
                end
            end
            rbgr_pkg::ST_FIN: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = rbgr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rbgr_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbgr_pkg::ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_done      <= '0;
            r_width     <= rbgr_pkg::RETIRE_WIDTH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_done      <= n_done;
            r_width     <= n_width;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_res     <= n_res;
        r_out     <= n_out;
        r_scan    <= n_scan;
        r_pend    <= n_pend;
        r_left    <= n_left;
        r_retired <= n_retired;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_end_mem[r_tail] <= r_item.last_in_inst;
        end
        r_end_q <= r_end_mem[r_scan];
    end

endmodule

`default_nettype wire
